>>> src/cctc_pkg.sv
// Shared widths, limits and month table for the calendar clock tick counter.
package cctc_pkg;

	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned H12_W   = 4;
	localparam int unsigned REM_W   = 7;
	localparam int unsigned CENT_W  = 2;

	localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
	localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(59);
	localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(59);
	localparam logic [HOUR_W-1:0]  HOUR_LAST  = HOUR_W'(23);
	localparam logic [HOUR_W-1:0]  HOUR_NOON  = HOUR_W'(12);
	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
	localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_LEAP   = DAY_W'(29);
	localparam logic [REM_W-1:0]   REM_LAST   = REM_W'(99);

	// year / 100 as (year * RECIP) >> RECIP_SH, exact for every 14-bit year
	localparam int unsigned RECIP_SH = 19;
	localparam int unsigned RECIP_W  = 13;
	localparam int unsigned PROD_W   = YEAR_W + RECIP_W;
	localparam int unsigned QUOT_W   = 8;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(5243);

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                 len = DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
			default:              len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

>>> src/calendar_clock_tick_counter_core.sv
// Real-time clock with Gregorian calendar: tick or load in, current date and time out.
//
// Input channel (in_valid/in_ready): one word per second tick (mode 0) or one
// word that loads a full date and time (mode 1). Output channel
// (out_valid/out_ready): one word per input word with the date and time after
// it, a midnight flag and the 12-hour display form.
// An accepted word sits in the input register, and from there moves through
// the tick cascade into the clock state, which is also the output register.
// Throughput is one word per cycle while the receiver does not stall; the rate
// is set by the combinational carry chain second-minute-hour-day-month-
// year. Leap years use a kept remainder of year modulo 100 and the century
// count modulo 4; a loaded year gets these from a reciprocal multiply in front
// of the input register.
// Reset sets 00:00:00 on day 1, January, year 0, with both channels empty.
// When the receiver stalls the result holds; the input register still takes
// one more word, then in_ready drops until the result is taken.
module calendar_clock_tick_counter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [cctc_pkg::SEC_W-1:0]     load_second,
	input  logic [cctc_pkg::MIN_W-1:0]     load_minute,
	input  logic [cctc_pkg::HOUR_W-1:0]    load_hour,
	input  logic [cctc_pkg::DAY_W-1:0]     load_day,
	input  logic [cctc_pkg::MONTH_W-1:0]   load_month,
	input  logic [cctc_pkg::YEAR_W-1:0]    load_year,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cctc_pkg::SEC_W-1:0]     cur_second,
	output logic [cctc_pkg::MIN_W-1:0]     cur_minute,
	output logic [cctc_pkg::HOUR_W-1:0]    cur_hour,
	output logic [cctc_pkg::DAY_W-1:0]     cur_day,
	output logic [cctc_pkg::MONTH_W-1:0]   cur_month,
	output logic [cctc_pkg::YEAR_W-1:0]    cur_year,
	output logic                           day_rolled,
	output logic [cctc_pkg::H12_W-1:0]     hour_twelve,
	output logic                           is_pm
);
	import cctc_pkg::*;

	// input register
	logic                valid_s1;
	logic                mode_s1;
	logic [SEC_W-1:0]    sec_s1;
	logic [MIN_W-1:0]    min_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [DAY_W-1:0]    day_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [YEAR_W-1:0]   year_s1;
	logic [REM_W-1:0]    rem_s1;
	logic [CENT_W-1:0]   cent_s1;

	// clock state, doubling as output register
	logic                out_valid_q;
	logic [SEC_W-1:0]    sec_q;
	logic [MIN_W-1:0]    min_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [DAY_W-1:0]    day_q;
	logic [MONTH_W-1:0]  month_q;
	logic [YEAR_W-1:0]   year_q;
	logic [REM_W-1:0]    rem_q;
	logic [CENT_W-1:0]   cent_q;
	logic                rolled_q;
	logic [H12_W-1:0]    h12_q;
	logic                pm_q;

	logic                advance;
	logic [PROD_W-1:0]   ld_prod;
	logic [QUOT_W-1:0]   ld_quot;
	logic [YEAR_W:0]     ld_hund;
	logic [YEAR_W-1:0]   ld_rem;

	logic                sec_wrap, min_wrap, hour_wrap;
	logic                leap;
	logic [DAY_W-1:0]    last_day;
	logic                day_wrap, month_wrap;
	logic [SEC_W-1:0]    sec_d;
	logic [MIN_W-1:0]    min_d;
	logic [HOUR_W-1:0]   hour_d;
	logic [DAY_W-1:0]    day_d;
	logic [MONTH_W-1:0]  month_d;
	logic [YEAR_W-1:0]   year_d;
	logic [REM_W-1:0]    rem_d;
	logic [CENT_W-1:0]   cent_d;
	logic                rolled_d;
	logic [H12_W-1:0]    h12_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// split loaded year into year mod 100 and century mod 4
	assign ld_prod = PROD_W'(load_year) * PROD_W'(RECIP);
	assign ld_quot = ld_prod[RECIP_SH +: QUOT_W];
	assign ld_hund = (YEAR_W+1)'({ld_quot, 6'b0}) + (YEAR_W+1)'({ld_quot, 5'b0})
			+ (YEAR_W+1)'({ld_quot, 2'b0});
	assign ld_rem  = load_year - ld_hund[YEAR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			sec_s1   <= load_second;
			min_s1   <= load_minute;
			hour_s1  <= load_hour;
			day_s1   <= load_day;
			month_s1 <= load_month;
			year_s1  <= load_year;
			rem_s1   <= ld_rem[REM_W-1:0];
			cent_s1  <= ld_quot[CENT_W-1:0];
		end
	end

	// tick cascade, load override and 12-hour form
	always_comb begin
		sec_wrap   = sec_q >= SEC_LAST;
		min_wrap   = sec_wrap && (min_q >= MIN_LAST);
		hour_wrap  = min_wrap && (hour_q >= HOUR_LAST);
		leap       = (year_q[1:0] == 2'b00) && ((rem_q != '0) || (cent_q == '0));
		last_day   = (month_q == MONTH_FEB && leap) ? DAY_LEAP : month_len(month_q);
		day_wrap   = hour_wrap && (day_q >= last_day);
		month_wrap = day_wrap && (month_q >= MONTH_DEC);

		sec_d   = sec_wrap ? '0 : sec_q + SEC_W'(1);
		min_d   = !sec_wrap ? min_q : (min_wrap ? '0 : min_q + MIN_W'(1));
		hour_d  = !min_wrap ? hour_q : (hour_wrap ? '0 : hour_q + HOUR_W'(1));
		day_d   = !hour_wrap ? day_q : (day_wrap ? DAY_FIRST : day_q + DAY_W'(1));
		month_d = !day_wrap ? month_q : (month_wrap ? MONTH_JAN : month_q + MONTH_W'(1));
		year_d  = year_q;
		rem_d   = rem_q;
		cent_d  = cent_q;
		if (month_wrap) begin
			if (year_q >= MAX_YEAR) begin
				year_d = '0;
				rem_d  = '0;
				cent_d = '0;
			end else begin
				year_d = year_q + YEAR_W'(1);
				if (rem_q >= REM_LAST) begin
					rem_d  = '0;
					cent_d = cent_q + CENT_W'(1);
				end else begin
					rem_d  = rem_q + REM_W'(1);
				end
			end
		end
		rolled_d = hour_wrap;

		if (mode_s1) begin
			sec_d    = sec_s1;
			min_d    = min_s1;
			hour_d   = hour_s1;
			day_d    = day_s1;
			month_d  = month_s1;
			year_d   = year_s1;
			rem_d    = rem_s1;
			cent_d   = cent_s1;
			rolled_d = 1'b0;
		end

		if (hour_d == '0) begin
			h12_d = H12_W'(12);
		end else if (hour_d <= HOUR_NOON) begin
			h12_d = hour_d[H12_W-1:0];
		end else begin
			h12_d = H12_W'(hour_d - HOUR_NOON);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= DAY_FIRST;
			month_q     <= MONTH_JAN;
			year_q      <= '0;
			rem_q       <= '0;
			cent_q      <= '0;
			rolled_q    <= 1'b0;
			h12_q       <= H12_W'(12);
			pm_q        <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			sec_q       <= sec_d;
			min_q       <= min_d;
			hour_q      <= hour_d;
			day_q       <= day_d;
			month_q     <= month_d;
			year_q      <= year_d;
			rem_q       <= rem_d;
			cent_q      <= cent_d;
			rolled_q    <= rolled_d;
			h12_q       <= h12_d;
			pm_q        <= hour_d >= HOUR_NOON;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign cur_second  = sec_q;
	assign cur_minute  = min_q;
	assign cur_hour    = hour_q;
	assign cur_day     = day_q;
	assign cur_month   = month_q;
	assign cur_year    = year_q;
	assign day_rolled  = rolled_q;
	assign hour_twelve = h12_q;
	assign is_pm       = pm_q;

	a_roll_at_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && day_rolled |-> cur_hour == '0 && cur_minute == '0 && cur_second == '0)
		else $error("day_rolled without midnight");

	a_pm_matches_hour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_pm == (cur_hour >= HOUR_NOON))
		else $error("is_pm disagrees with cur_hour");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without full pipeline");

	a_year_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !mode_s1 |=> rem_q <= REM_LAST)
		else $error("year remainder out of range after tick");
endmodule
